// ----- sv/per_peer_anti_replay_window_core_assert.svh -----
// assertion macros for the per-peer anti-replay window core
// expects clock and reset to be visible where the macros are used
`ifndef PER_PEER_ANTI_REPLAY_WINDOW_CORE_ASSERT_SVH
`define PER_PEER_ANTI_REPLAY_WINDOW_CORE_ASSERT_SVH

// same-cycle implication, ignored during reset
`define PPAR_ASSERT_IMPL(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("ppar assertion failed");

// next-cycle implication, ignored during reset
`define PPAR_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("ppar assertion failed");

// same-cycle implication that is also checked around reset
`define PPAR_ASSERT_ALWAYS(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) (ante) |-> (cons)) \
      else $error("ppar assertion failed");

`endif

// ----- sv/ppar_pkg.sv -----
// shared constants and control types for the per-peer anti-replay window core
// no dependencies
package ppar_pkg;

   localparam int PEER_SLOTS  = 256;
   localparam int WINDOW_BITS = 64;

   localparam int SEQ_W     = 64;
   localparam int PORT_W    = 16;
   localparam int SLOT_IN_W = 8;
   localparam int SLOT_W    = (PEER_SLOTS > 1) ? $clog2(PEER_SLOTS) : 1;
   localparam int SHIFT_W   = $clog2(WINDOW_BITS);

   localparam logic [PORT_W-1:0] LISTEN_PORT_RESET = 16'd50000;

   // commands from the controller to the datapath
   typedef struct packed {
      logic load;     // capture the item and read its window
      logic sub;      // subtract window top from the sequence
      logic span;     // form the distance and the far flag
      logic commit;   // update the window and load the result register
   } ppar_cmd_type;

   // status from the datapath to the controller
   typedef struct packed {
      logic req_checked;  // the offered item needs a window check
      logic out_free;     // the result register can take a new result
   } ppar_status_type;

endpackage

// ----- sv/ppar_ifs.sv -----
// valid/ready channel interfaces for packet descriptors and verdicts
// depends on ppar_pkg
interface ppar_req_if import ppar_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic                 is_udp;
   logic [PORT_W-1:0]    dest_port;
   logic                 peer_found;
   logic [SLOT_IN_W-1:0] peer_slot;
   logic [SEQ_W-1:0]     packet_seq;

   modport source (output valid, is_udp, dest_port, peer_found, peer_slot, packet_seq,
                   input ready);
   modport sink   (input valid, is_udp, dest_port, peer_found, peer_slot, packet_seq,
                   output ready);
endinterface

interface ppar_rsp_if ();
   logic valid;
   logic ready;
   logic verdict;
   logic was_checked;

   modport source (output valid, verdict, was_checked, input ready);
   modport sink   (input valid, verdict, was_checked, output ready);
endinterface

// ----- sv/ppar_ctrl.sv -----
// sequencer for the anti-replay window core: steps one item through read, subtract,
// distance and update, unchecked items from read straight to update; depends on ppar_pkg
module ppar_ctrl import ppar_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  ppar_status_type status,
   output ppar_cmd_type    cmd
);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_SUB   = 2'd1;
   localparam logic [1:0] ST_DIST  = 2'd2;
   localparam logic [1:0] ST_APPLY = 2'd3;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_ready  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               // unchecked packets go straight to the result
               state_in = status.req_checked ? ST_SUB : ST_APPLY;
            end
         end
         ST_SUB: begin
            cmd.sub  = 1'b1;
            state_in = ST_DIST;
         end
         ST_DIST: begin
            cmd.span = 1'b1;
            state_in = ST_APPLY;
         end
         ST_APPLY: begin
            if (status.out_free) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ----- sv/ppar_datapath.sv -----
// window storage, sequence arithmetic, listen port register and result register
// depends on ppar_pkg
module ppar_datapath import ppar_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  ppar_cmd_type         cmd,
   output ppar_status_type      status,
   input  logic                 req_is_udp,
   input  logic [PORT_W-1:0]    req_dest_port,
   input  logic                 req_peer_found,
   input  logic [SLOT_IN_W-1:0] req_peer_slot,
   input  logic [SEQ_W-1:0]     req_packet_seq,
   input  logic                 csr_wr_en,
   input  logic [PORT_W-1:0]    csr_wr_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic                 rsp_verdict,
   output logic                 rsp_was_checked
);

   localparam int ENTRY_W = SEQ_W + WINDOW_BITS;

   // window store: top in the upper bits, bitmap in the lower bits
   logic [ENTRY_W-1:0]     mem [PEER_SLOTS];
   logic [PEER_SLOTS-1:0]  entry_valid_ff;

   logic [PORT_W-1:0]      listen_port_ff;
   logic [SEQ_W-1:0]       seq_ff;
   logic [SLOT_W-1:0]      slot_ff;
   logic                   checked_ff;
   logic [ENTRY_W-1:0]     rd_data_ff;
   logic                   rd_valid_ff;
   logic [SEQ_W-1:0]       diff_ff;
   logic                   le_ff;
   logic                   far_ff;
   logic [SHIFT_W-1:0]     shamt_ff;
   logic                   rsp_valid_ff;
   logic                   verdict_ff;
   logic                   was_checked_ff;

   logic                   slot_ok;
   logic [SLOT_W-1:0]      req_slot;
   logic [SEQ_W-1:0]       top;
   logic [WINDOW_BITS-1:0] bits;
   logic [SEQ_W:0]         sub_full;
   logic [SEQ_W-1:0]       gap;
   logic                   hit;
   logic                   drop;
   logic [WINDOW_BITS-1:0] new_bits;
   logic [SEQ_W-1:0]       new_top;
   logic                   rsp_valid_in;

   assign slot_ok  = (32'(req_peer_slot) < PEER_SLOTS);
   assign req_slot = SLOT_W'(req_peer_slot);

   assign status.req_checked = req_is_udp && (req_dest_port == listen_port_ff) &&
                               req_peer_found && slot_ok;
   assign status.out_free    = !rsp_valid_ff || rsp_ready;

   // an entry never written since reset reads as an empty window at top 0
   assign top  = rd_valid_ff ? rd_data_ff[ENTRY_W-1:WINDOW_BITS] : '0;
   assign bits = rd_valid_ff ? rd_data_ff[WINDOW_BITS-1:0] : '0;

   assign sub_full = {1'b0, seq_ff} - {1'b0, top};
   assign gap      = le_ff ? (~diff_ff + SEQ_W'(1)) : diff_ff;

   assign hit  = bits[shamt_ff];
   assign drop = le_ff && (far_ff || hit);

   always_comb begin
      new_top  = top;
      new_bits = bits;
      if (le_ff) begin
         new_bits = bits | (WINDOW_BITS'(1) << shamt_ff);
      end else begin
         new_top = seq_ff;
         if (far_ff) begin
            new_bits = WINDOW_BITS'(1);
         end else begin
            new_bits = (bits << shamt_ff) | WINDOW_BITS'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         listen_port_ff <= LISTEN_PORT_RESET;
      end else if (csr_wr_en) begin
         listen_port_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         seq_ff      <= req_packet_seq;
         slot_ff     <= req_slot;
         checked_ff  <= status.req_checked;
         rd_data_ff  <= mem[req_slot];
         rd_valid_ff <= entry_valid_ff[req_slot];
      end
      if (cmd.sub) begin
         diff_ff <= sub_full[SEQ_W-1:0];
         le_ff   <= sub_full[SEQ_W] || (sub_full[SEQ_W-1:0] == '0);
      end
      if (cmd.span) begin
         far_ff   <= (gap >= SEQ_W'(WINDOW_BITS));
         shamt_ff <= gap[SHIFT_W-1:0];
      end
      if (cmd.commit && checked_ff && !drop) begin
         mem[slot_ff] <= {new_top, new_bits};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_valid_ff <= '0;
      end else if (cmd.commit && checked_ff && !drop) begin
         entry_valid_ff[slot_ff] <= 1'b1;
      end
   end

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         verdict_ff     <= checked_ff && drop;
         was_checked_ff <= checked_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_verdict     = verdict_ff;
   assign rsp_was_checked = was_checked_ff;

endmodule

// ----- sv/per_peer_anti_replay_window_core.sv -----
// Per-peer anti-replay window core. Each packet descriptor transfer is checked against a
// 64-bit sliding window (highest sequence seen plus a seen bitmap) kept per peer slot in an
// internal memory; UDP packets to the listen port from a known peer in range are checked,
// all others are accepted unchecked. One item is in work at a time: a checked packet passes
// through window read, 64-bit subtract, distance, then window update and write-back, with the
// result loaded into the output register; an unchecked one goes from the read straight to the
// update. The next descriptor is taken as soon as the result is registered, even if it waits
// on rsp_chan; the update step stalls while the previous result is still waiting. Windows
// read as empty at top 0 after reset through per-slot valid bits, so no clearing pass is
// needed. The user must write listen_port through csr_wr_en/csr_wr_data only while idle;
// the block itself does not enforce it.
// Depends on ppar_pkg, ppar_ifs, ppar_ctrl and ppar_datapath.
module per_peer_anti_replay_window_core import ppar_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   ppar_req_if.sink          req_chan,
   ppar_rsp_if.source        rsp_chan,
   input  logic              csr_wr_en,
   input  logic [PORT_W-1:0] csr_wr_data
);

   ppar_cmd_type    cmd;
   ppar_status_type status;
   logic            req_ready;

   ppar_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   ppar_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_is_udp      (req_chan.is_udp),
      .req_dest_port   (req_chan.dest_port),
      .req_peer_found  (req_chan.peer_found),
      .req_peer_slot   (req_chan.peer_slot),
      .req_packet_seq  (req_chan.packet_seq),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .rsp_valid       (rsp_chan.valid),
      .rsp_ready       (rsp_chan.ready),
      .rsp_verdict     (rsp_chan.verdict),
      .rsp_was_checked (rsp_chan.was_checked)
   );

   assign req_chan.ready = req_ready;

endmodule

// ----- sv/ppar_checker.sv -----
// port-level checks for the anti-replay window core, bound to the top level
// depends on per_peer_anti_replay_window_core_assert.svh
`include "per_peer_anti_replay_window_core_assert.svh"

module ppar_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic rsp_verdict,
   input logic rsp_was_checked
);

   // result stays offered until its transfer
   `PPAR_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid)

   // one item in work at a time
   `PPAR_ASSERT_NEXT(a_one_in_work, req_valid && req_ready, !req_ready)

   // a drop only comes from a window check
   `PPAR_ASSERT_IMPL(a_drop_checked, rsp_valid && rsp_verdict, rsp_was_checked)

   // no stale result right after reset
   `PPAR_ASSERT_ALWAYS(a_reset_empty, $past(reset), !rsp_valid)

endmodule

bind per_peer_anti_replay_window_core ppar_checker u_ppar_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_chan.valid),
   .req_ready       (req_chan.ready),
   .rsp_valid       (rsp_chan.valid),
   .rsp_ready       (rsp_chan.ready),
   .rsp_verdict     (rsp_chan.verdict),
   .rsp_was_checked (rsp_chan.was_checked)
);

// ----- tb/sv/per_peer_anti_replay_window_checker.sv -----
// watches the descriptor, verdict and csr ports of the anti-replay window core,
// keeps its own copy of every peer window and compares each verdict transfer
// depends on ppar_pkg and ppar_ifs
module per_peer_anti_replay_window_checker import ppar_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   ppar_req_if               req_mon,
   ppar_rsp_if               rsp_mon,
   input  logic              csr_wr_en,
   input  logic [PORT_W-1:0] csr_wr_data,
   output int unsigned       mismatch_count,
   output int unsigned       verdicts_owed
);

   typedef struct packed {
      logic verdict;
      logic was_checked;
   } verdict_type;

   logic [SEQ_W-1:0]       win_top  [PEER_SLOTS];
   logic [WINDOW_BITS-1:0] win_seen [PEER_SLOTS];
   logic [PORT_W-1:0]      port_cfg;
   verdict_type            owed_q[$];
   int unsigned            miss_n;

   // judges one descriptor and slides the window of its slot on accept
   function automatic verdict_type judge_packet(
         input logic udp, input logic [PORT_W-1:0] dport,
         input logic found, input logic [SLOT_IN_W-1:0] slot,
         input logic [SEQ_W-1:0] seq);
      verdict_type            r;
      logic [SEQ_W-1:0]       top;
      logic [SEQ_W-1:0]       gap;
      logic [WINDOW_BITS-1:0] seen;
      logic [WINDOW_BITS-1:0] one_hot;
      r = '0;
      if (!udp || dport != port_cfg || !found || 32'(slot) >= PEER_SLOTS) begin
         return r;
      end
      r.was_checked = 1'b1;
      top = win_top[slot];
      seen = win_seen[slot];
      if (seq <= top) begin
         gap = top - seq;
         if (gap >= WINDOW_BITS) begin
            r.verdict = 1'b1;
         end else if (seen[gap[SHIFT_W-1:0]]) begin
            r.verdict = 1'b1;
         end else begin
            one_hot = '0;
            one_hot[gap[SHIFT_W-1:0]] = 1'b1;
            win_seen[slot] = seen | one_hot;
         end
      end else begin
         gap = seq - top;
         // a full window jump or more restarts the bitmap
         if (gap >= WINDOW_BITS) begin
            win_seen[slot] = WINDOW_BITS'(1);
         end else begin
            win_seen[slot] = (seen << gap[SHIFT_W-1:0]) | WINDOW_BITS'(1);
         end
         win_top[slot] = seq;
      end
      return r;
   endfunction

   always @(posedge clock) begin
      verdict_type want;
      verdict_type got;
      if (reset) begin
         for (int i = 0; i < PEER_SLOTS; i++) begin
            win_top[i] = '0;
            win_seen[i] = '0;
         end
         port_cfg = LISTEN_PORT_RESET;
         owed_q.delete();
         miss_n = 0;
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            got.verdict = rsp_mon.verdict;
            got.was_checked = rsp_mon.was_checked;
            if (owed_q.size() == 0) begin
               if (miss_n < 10) begin
                  $display("unexpected verdict transfer: verdict=%0d checked=%0d",
                           got.verdict, got.was_checked);
               end
               miss_n++;
            end else begin
               want = owed_q.pop_front();
               if (got !== want) begin
                  if (miss_n < 10) begin
                     $display({"verdict mismatch: expected verdict=%0d checked=%0d, ",
                               "got verdict=%0d checked=%0d"},
                              want.verdict, want.was_checked, got.verdict, got.was_checked);
                  end
                  miss_n++;
               end
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            owed_q.push_back(judge_packet(req_mon.is_udp, req_mon.dest_port, req_mon.peer_found,
                                          req_mon.peer_slot, req_mon.packet_seq));
         end
         // the core sees a new listen port only from the next transfer on
         if (csr_wr_en) begin
            port_cfg = csr_wr_data;
         end
      end
      mismatch_count <= miss_n;
      verdicts_owed <= owed_q.size();
   end

endmodule

// ----- tb/sv/per_peer_anti_replay_window_core_tb.sv -----
// top of the anti-replay window core bench: clock, reset, descriptor stimulus,
// verdict back-pressure and listen port writes; the checker does the comparing
// depends on ppar_pkg, ppar_ifs, the core and per_peer_anti_replay_window_checker
module per_peer_anti_replay_window_core_tb;
   import ppar_pkg::*;

   localparam int ITEMS_PER_PHASE = 445;
   localparam int RSP_HOLD_CYCLES = 300;
   localparam int SETTLE_CYCLES   = 8;
   localparam logic [SEQ_W-1:0] SEQ_MAX = '1;

   logic              clock;
   logic              reset;
   logic              csr_wr_en;
   logic [PORT_W-1:0] csr_wr_data;
   int unsigned       mismatch_count;
   int unsigned       verdicts_owed;
   logic              no_idle;
   logic              hold_rsp;
   logic [PORT_W-1:0] cur_port;
   logic [SEQ_W-1:0]  seq_hint [PEER_SLOTS];

   ppar_req_if req_chan ();
   ppar_rsp_if rsp_chan ();

   per_peer_anti_replay_window_core dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   per_peer_anti_replay_window_checker checker_i (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_chan),
      .rsp_mon        (rsp_chan),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .mismatch_count (mismatch_count),
      .verdicts_owed  (verdicts_owed)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #3000000;
      $display("status: fail");
      $finish;
   end

   // verdict receiver: random stalls, a long hold-off on request
   initial begin
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_rsp) begin
            rsp_chan.ready <= 1'b0;
            hold_rsp <= 1'b0;
            repeat (RSP_HOLD_CYCLES - 1) @(posedge clock);
         end else begin
            rsp_chan.ready <= no_idle | ($urandom_range(0, 99) >= 21);
         end
      end
   end

   task automatic offer_desc(input logic udp, input logic [PORT_W-1:0] dport, input logic found,
                             input logic [SLOT_IN_W-1:0] slot, input logic [SEQ_W-1:0] seq);
      if (!no_idle) begin
         while ($urandom_range(0, 99) < 21) begin
            req_chan.valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_chan.valid      <= 1'b1;
      req_chan.is_udp     <= udp;
      req_chan.dest_port  <= dport;
      req_chan.peer_found <= found;
      req_chan.peer_slot  <= slot;
      req_chan.packet_seq <= seq;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      if (udp && found && dport == cur_port && seq > seq_hint[slot]) begin
         seq_hint[slot] = seq;
      end
   endtask

   // mostly well-formed packets near the window top of a few busy slots
   task automatic offer_random();
      logic                 udp;
      logic                 found;
      logic [PORT_W-1:0]    dport;
      logic [SLOT_IN_W-1:0] slot;
      logic [SEQ_W-1:0]     base;
      logic [SEQ_W-1:0]     seq;
      slot = ($urandom_range(0, 3) == 0) ? SLOT_IN_W'($urandom) : SLOT_IN_W'($urandom_range(0, 7));
      base = seq_hint[slot];
      case ($urandom_range(0, 19))
         0, 1, 2, 3, 4, 5: seq = base + $urandom_range(1, 3);
         6, 7, 8, 9, 10:   seq = base - $urandom_range(0, 70);
         11, 12:           seq = base + $urandom_range(60, 70);
         13, 14:           seq = base;
         15, 16:           seq = base - $urandom_range(60, 68);
         17:               seq = (slot >= 8) ? SEQ_MAX - $urandom_range(0, 80) : base + 1;
         default:          seq = {$urandom, $urandom};
      endcase
      if ($urandom_range(0, 99) < 15) begin
         udp   = 1'($urandom_range(0, 1));
         found = 1'($urandom_range(0, 1));
         dport = ($urandom_range(0, 3) == 0) ? cur_port : PORT_W'($urandom);
      end else begin
         udp   = 1'b1;
         found = 1'b1;
         dport = cur_port;
      end
      offer_desc(udp, dport, found, slot, seq);
   endtask

   // sender pause until every verdict is back, then let the core go quiet
   task automatic settle();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (verdicts_owed != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_listen_port(input logic [PORT_W-1:0] value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      @(posedge clock);
      cur_port = value;
   endtask

   initial begin
      logic [PORT_W-1:0] port_set [4];
      reset               <= 1'b1;
      csr_wr_en           <= 1'b0;
      csr_wr_data         <= '0;
      no_idle             <= 1'b0;
      hold_rsp            <= 1'b0;
      req_chan.valid      <= 1'b0;
      req_chan.is_udp     <= 1'b0;
      req_chan.dest_port  <= '0;
      req_chan.peer_found <= 1'b0;
      req_chan.peer_slot  <= '0;
      req_chan.packet_seq <= '0;
      cur_port = LISTEN_PORT_RESET;
      for (int i = 0; i < PEER_SLOTS; i++) seq_hint[i] = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // unchecked packets: not udp, wrong port, unknown peer
      offer_desc(1'b0, cur_port, 1'b1, 8'd0, 64'd0);
      offer_desc(1'b1, cur_port ^ 16'd1, 1'b1, 8'd0, 64'd0);
      offer_desc(1'b1, cur_port, 1'b0, 8'd0, 64'd0);
      // sequence zero at the reset top, then replayed
      offer_desc(1'b1, cur_port, 1'b1, 8'd0, 64'd0);
      offer_desc(1'b1, cur_port, 1'b1, 8'd0, 64'd0);
      offer_desc(1'b1, cur_port, 1'b1, 8'd0, 64'd1);
      offer_desc(1'b1, cur_port, 1'b1, 8'd0, 64'd64);
      offer_desc(1'b1, cur_port, 1'b1, 8'd0, 64'd1);
      offer_desc(1'b1, cur_port, 1'b1, 8'd0, 64'd0);
      // full window jump restarts the bitmap
      offer_desc(1'b1, cur_port, 1'b1, 8'd0, 64'd200);
      offer_desc(1'b1, cur_port, 1'b1, 8'd0, 64'd199);
      offer_desc(1'b1, cur_port, 1'b1, 8'd0, 64'd136);
      offer_desc(1'b1, cur_port, 1'b1, 8'd0, 64'd137);
      // top slot at the largest sequences
      offer_desc(1'b1, cur_port, 1'b1, 8'hFF, SEQ_MAX);
      offer_desc(1'b1, cur_port, 1'b1, 8'hFF, SEQ_MAX - 64'd63);
      offer_desc(1'b1, cur_port, 1'b1, 8'hFF, SEQ_MAX - 64'd64);
      offer_desc(1'b1, cur_port, 1'b1, 8'hFF, 64'd0);
      // back to back on one slot
      offer_desc(1'b1, cur_port, 1'b1, 8'd7, 64'd5);
      offer_desc(1'b1, cur_port, 1'b1, 8'd7, 64'd6);
      offer_desc(1'b1, cur_port, 1'b1, 8'd7, 64'd6);
      // extreme ports that do not match the listen port
      offer_desc(1'b1, 16'hFFFF, 1'b1, 8'hFF, SEQ_MAX);
      offer_desc(1'b1, 16'h0000, 1'b1, 8'hFF, SEQ_MAX);

      port_set[0] = 16'h0000;
      port_set[1] = 16'hFFFF;
      port_set[2] = PORT_W'($urandom);
      port_set[3] = LISTEN_PORT_RESET;
      for (int ph = 0; ph < 4; ph++) begin
         settle();
         write_listen_port(port_set[ph]);
         if (ph == 1) no_idle <= 1'b1;
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            if (ph == 0 && n == 100) hold_rsp <= 1'b1;
            if (ph == 1 && n == 200) no_idle <= 1'b0;
            if (ph == 2 && n == 225) settle();
            offer_random();
         end
      end

      settle();
      repeat (20) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
